[rtl/core/gnc_pkg.sv]
// Shared types, constants and helper functions of the grid neighborhood change block.
`timescale 1ns / 1ps

package gnc_pkg;

    localparam int CELL_W         = 16;
    localparam int DIM_W          = 9;
    localparam int DEST_W         = 17;
    localparam int CLASS_W        = 2;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;
    localparam int NB_CELLS       = 9;
    localparam int INDEX_BITS_DEF = 16;

    // Two quotient bits per divider step
    localparam int DIV_STEPS  = CELL_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);
    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(256);

    localparam logic REG_GRID_COLS = 1'b0;
    localparam logic REG_GRID_ROWS = 1'b1;

    localparam logic [CLASS_W-1:0] CLASS_ENTERED   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_EXITED    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_UNCHANGED = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] grid_cols;
        logic [DIM_W-1:0] grid_rows;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mask_load;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic pend_empty;
        logic out_free;
        logic pick_last;
    } sts_t;

    // Zero acts as one, anything above 256 acts as 256
    function automatic logic [DIM_W-1:0] dim_eff(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0)
            d = DIM_W'(1);
        else if (v > DIM_MAX)
            d = DIM_MAX;
        else
            d = v;
        return d;
    endfunction

endpackage

[rtl/core/grid_neighborhood_change.sv]
// An item is accepted, then divided, masked and merged; in_stall stays high until its N results
// (0..18, one per cycle when not stalled) have been emitted, and no result follows when N is 0.
// The steps are the 8-step two-lane radix-4 divider that splits both centers into
// row and column, one mask-build state, and the merge that emits one cell per cycle when not stalled.
// rst_n clears the center (no center), the sequencer and the output valid, and loads
// grid_cols and grid_rows with 16; the block takes items from the first cycle after reset.
`timescale 1ns / 1ps

module grid_neighborhood_change #(
    parameter int INDEX_BITS = gnc_pkg::INDEX_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gnc_pkg::ADDR_W-1:0]        paddr,
    input  logic [gnc_pkg::DATA_W-1:0]        pwdata,
    output logic [gnc_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [gnc_pkg::DEST_W-1:0] dest_cell,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [gnc_pkg::CELL_W-1:0]        cell_index,
    output logic [gnc_pkg::CLASS_W-1:0]       change_class,
    output logic                              last_cell
);
    import gnc_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    gnc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    gnc_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .dest_cell    (dest_cell),
        .cmd          (cmd),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .cell_index   (cell_index),
        .change_class (change_class),
        .last_cell    (last_cell)
    );

endmodule

[rtl/core/gnc_cfg.sv]
// APB register file holding the grid dimensions.
`timescale 1ns / 1ps

module gnc_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gnc_pkg::ADDR_W-1:0] paddr,
    input  logic [gnc_pkg::DATA_W-1:0] pwdata,
    output logic [gnc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output gnc_pkg::cfg_t              cfg
);
    import gnc_pkg::*;

    logic [DIM_W-1:0] cols_reg;
    logic [DIM_W-1:0] rows_reg;
    logic             reg_sel;

    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= DIM_RESET;
            rows_reg <= DIM_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_GRID_COLS: cols_reg <= pwdata[DIM_W-1:0];
                REG_GRID_ROWS: rows_reg <= pwdata[DIM_W-1:0];
                default:       cols_reg <= cols_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_GRID_COLS: prdata = DATA_W'(cols_reg);
            REG_GRID_ROWS: prdata = DATA_W'(rows_reg);
            default:       prdata = '0;
        endcase
    end

    assign cfg.grid_cols = cols_reg;
    assign cfg.grid_rows = rows_reg;

endmodule

[rtl/core/gnc_div.sv]
// Two-lane radix-4 restoring divider splitting cell indexes into row and column.
`timescale 1ns / 1ps

module gnc_div (
    input  logic                             clk,
    input  logic                             start,
    input  logic                             step,
    input  logic [1:0][gnc_pkg::CELL_W-1:0]  dividend,
    input  logic [gnc_pkg::DIM_W-1:0]        divisor,
    output logic [1:0][gnc_pkg::CELL_W-1:0]  quotient,
    output logic [1:0][gnc_pkg::DIM_W-1:0]   remainder
);
    import gnc_pkg::*;

    logic [1:0][CELL_W-1:0] quo_reg, quo_next;
    logic [1:0][DIM_W-1:0]  rem_reg, rem_next;

    always_comb
    begin
        logic [DIM_W:0]  trial;
        logic [CELL_W-1:0] q;
        logic [DIM_W-1:0]  r;
        for (int s = 0; s < 2; s++)
        begin
            q = quo_reg[s];
            r = rem_reg[s];
            // Two restoring iterations per step
            for (int i = 0; i < 2; i++)
            begin
                trial = {r, q[CELL_W-1]};
                if (trial >= {1'b0, divisor})
                begin
                    trial = trial - {1'b0, divisor};
                    q     = {q[CELL_W-2:0], 1'b1};
                end
                else
                begin
                    q     = {q[CELL_W-2:0], 1'b0};
                end
                r = trial[DIM_W-1:0];
            end
            quo_next[s] = q;
            rem_next[s] = r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/gnc_dp.sv]
// Datapath: center state, neighborhood masks, ordered merge and output register.
`timescale 1ns / 1ps

module gnc_dp #(
    parameter int INDEX_BITS = gnc_pkg::INDEX_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gnc_pkg::cfg_t                     cfg,
    input  logic signed [gnc_pkg::DEST_W-1:0] dest_cell,
    input  gnc_pkg::cmd_t                     cmd,
    output gnc_pkg::sts_t                     sts,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [gnc_pkg::CELL_W-1:0]        cell_index,
    output logic [gnc_pkg::CLASS_W-1:0]       change_class,
    output logic                              last_cell
);
    import gnc_pkg::*;

    localparam logic [DEST_W-1:0] CAP_LIM =
        (INDEX_BITS >= DEST_W) ? {DEST_W{1'b1}} : DEST_W'(1 << INDEX_BITS);

    localparam logic [1:0] POS_LO  = 2'd0;
    localparam logic [1:0] POS_MID = 2'd1;
    localparam logic [1:0] POS_HI  = 2'd2;

    function automatic logic [1:0] pos_row(input logic [3:0] p);
        logic [1:0] v;
        unique case (p)
            4'd0, 4'd1, 4'd2: v = POS_LO;
            4'd3, 4'd4, 4'd5: v = POS_MID;
            4'd6, 4'd7, 4'd8: v = POS_HI;
            default:          v = POS_MID;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pos_col(input logic [3:0] p);
        logic [1:0] v;
        unique case (p)
            4'd0, 4'd3, 4'd6: v = POS_LO;
            4'd1, 4'd4, 4'd7: v = POS_MID;
            4'd2, 4'd5, 4'd8: v = POS_HI;
            default:          v = POS_MID;
        endcase
        return v;
    endfunction

    // Cell at grid position p around center c; off-grid positions do not wrap but are masked out
    function automatic logic [CELL_W+1:0] nb_cell(input logic [CELL_W-1:0] c,
                                                  input logic [DIM_W-1:0]  cols,
                                                  input logic [3:0]        p);
        logic [CELL_W+1:0] v;
        v = {2'b00, c};
        unique case (pos_row(p))
            POS_LO:  v = v - (CELL_W+2)'(cols);
            POS_HI:  v = v + (CELL_W+2)'(cols);
            default: v = v;
        endcase
        unique case (pos_col(p))
            POS_LO:  v = v - (CELL_W+2)'(1);
            POS_HI:  v = v + (CELL_W+2)'(1);
            default: v = v;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] first_set(input logic [NB_CELLS-1:0] m);
        logic [3:0] p;
        p = '0;
        for (int i = NB_CELLS - 1; i >= 0; i--)
        begin
            if (m[i])
                p = 4'(i);
        end
        return p;
    endfunction

    logic [DIM_W-1:0]   cols_eff;
    logic [DIM_W-1:0]   rows_eff;
    logic [2*DIM_W-1:0] prod;
    logic [DEST_W-1:0]  limit;

    logic [CELL_W-1:0]  center_reg;
    logic               center_valid_reg;
    logic [1:0][CELL_W-1:0] ctr_reg;
    logic [1:0]             side_ok_reg;
    logic [1:0][NB_CELLS-1:0] pend_reg, pend_after;
    logic [1:0][NB_CELLS-1:0] mask;

    logic [1:0][CELL_W-1:0] quo;
    logic [1:0][DIM_W-1:0]  rem;

    logic               old_ok, new_ok;
    logic [3:0]         po, pn;
    logic [CELL_W+1:0]  co, cn;
    logic               has_o, has_n;
    logic [CELL_W-1:0]  pick_cell;
    logic [CLASS_W-1:0] pick_class;

    logic               out_valid_reg;
    logic [CELL_W-1:0]  cell_reg;
    logic [CLASS_W-1:0] class_reg;
    logic               last_reg;

    assign cols_eff = dim_eff(cfg.grid_cols);
    assign rows_eff = dim_eff(cfg.grid_rows);
    assign prod     = cols_eff * rows_eff;
    assign limit    = (prod[DEST_W-1:0] < CAP_LIM) ? prod[DEST_W-1:0] : CAP_LIM;

    // A center that the grid no longer covers counts as none
    assign old_ok = center_valid_reg && ({1'b0, center_reg} < limit);
    assign new_ok = !dest_cell[DEST_W-1] && (DEST_W'(dest_cell) < limit);

    gnc_div u_div (
        .clk       (clk),
        .start     (cmd.load),
        .step      (cmd.div_step),
        .dividend  ({dest_cell[CELL_W-1:0], center_reg}),
        .divisor   (cols_eff),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        logic [1:0] rs, cs;
        logic       row_ok, col_ok, cell_ok;
        for (int s = 0; s < 2; s++)
        begin
            for (int p = 0; p < NB_CELLS; p++)
            begin
                rs = pos_row(4'(p));
                cs = pos_col(4'(p));
                row_ok = 1'b1;
                col_ok = 1'b1;
                if (rs == POS_LO)
                    row_ok = (quo[s] != '0);
                else if (rs == POS_HI)
                    row_ok = ({1'b0, quo[s]} + (CELL_W+1)'(1)) < (CELL_W+1)'(rows_eff);
                if (cs == POS_LO)
                    col_ok = (rem[s] != '0);
                else if (cs == POS_HI)
                    col_ok = ({1'b0, rem[s]} + (DIM_W+1)'(1)) < {1'b0, cols_eff};
                cell_ok = nb_cell(ctr_reg[s], cols_eff, 4'(p)) < {1'b0, limit};
                mask[s][p] = side_ok_reg[s] && row_ok && col_ok && cell_ok;
            end
        end
    end

    // Merge the two ascending streams one cell per emission
    always_comb
    begin
        has_o = (pend_reg[0] != '0);
        has_n = (pend_reg[1] != '0);
        po    = first_set(pend_reg[0]);
        pn    = first_set(pend_reg[1]);
        co    = nb_cell(ctr_reg[0], cols_eff, po);
        cn    = nb_cell(ctr_reg[1], cols_eff, pn);
        pend_after = pend_reg;
        if (has_o && has_n && (co == cn))
        begin
            pick_cell  = cn[CELL_W-1:0];
            pick_class = CLASS_UNCHANGED;
            pend_after[0][po] = 1'b0;
            pend_after[1][pn] = 1'b0;
        end
        else if (has_n && (!has_o || (cn < co)))
        begin
            pick_cell  = cn[CELL_W-1:0];
            pick_class = CLASS_ENTERED;
            pend_after[1][pn] = 1'b0;
        end
        else
        begin
            pick_cell  = co[CELL_W-1:0];
            pick_class = CLASS_EXITED;
            pend_after[0][po] = 1'b0;
        end
    end

    assign sts.pend_empty = !has_o && !has_n;
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.pick_last  = (pend_after == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg       <= '0;
            center_valid_reg <= 1'b0;
            side_ok_reg      <= '0;
            pend_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                side_ok_reg <= {new_ok, old_ok};
            end
            if (cmd.mask_load)
            begin
                pend_reg         <= mask;
                center_valid_reg <= side_ok_reg[1];
                center_reg       <= side_ok_reg[1] ? ctr_reg[1] : '0;
            end
            else if (cmd.emit)
            begin
                pend_reg <= pend_after;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ctr_reg[0] <= center_reg;
            ctr_reg[1] <= dest_cell[CELL_W-1:0];
        end
        if (cmd.emit)
        begin
            cell_reg  <= pick_cell;
            class_reg <= pick_class;
            last_reg  <= sts.pick_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_index   = cell_reg;
    assign change_class = class_reg;
    assign last_cell    = last_reg;

`ifndef SYNTHESIS
    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (pend_reg != '0))
        else $error("emission with no pending cell");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.pick_last) |=> (pend_reg == '0) && last_cell)
        else $error("last cell flagged with cells still pending");

    a_unchanged_needs_both: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && (pick_class == CLASS_UNCHANGED)) |-> (side_ok_reg == 2'b11))
        else $error("unchanged cell without both centers");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.emit)
        else $error("held item overwritten");
`endif

endmodule

[rtl/core/gnc_ctrl.sv]
// Controller sequencing accept, divide, mask build and result emission.
`timescale 1ns / 1ps

module gnc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output gnc_pkg::cmd_t cmd,
    input  gnc_pkg::sts_t sts
);
    import gnc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MASK = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_MASK;
            end
            ST_MASK:
            begin
                cmd.mask_load = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                priority if (sts.pend_empty)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (sts.pick_last)
                        state_next = ST_IDLE;
                end
                else
                begin
                    // Hold while the output register is stalled
                    state_next = ST_EMIT;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_DIV) && (cnt_reg == '0))
        else $error("divide did not start after accept");

    a_mask_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MASK) |-> $past(state_reg == ST_DIV))
        else $error("mask build without completed divide");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_step, cmd.mask_load, cmd.emit}))
        else $error("conflicting datapath commands");
`endif

endmodule
